FILE: sv/svpd_pkg.sv
// Shared types, constants and the phase role table for the space-vector PWM duty block.
`default_nettype none
package svpd_pkg;

  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector_code;
    logic        limited;
  } out_t;

  // Side data that travels alongside the divider pipeline
  typedef struct packed {
    logic [2:0]  sector;
    logic        limited;
    logic [16:0] s;
    logic [16:0] x;
  } mid_t;

  typedef enum logic [1:0] {
    ROLE_TRAIL = 2'd0,
    ROLE_MID   = 2'd1,
    ROLE_LEAD  = 2'd2
  } role_t;

  localparam logic [16:0] DUTY_ONE = 17'd32768;

  // Role of a phase (0 = A, 1 = B, 2 = C) for a sector code
  function automatic role_t phase_role(input logic [2:0] sec, input logic [1:0] ph);
    role_t r0, r1, r2;
    begin
      r0 = ROLE_TRAIL;
      r1 = ROLE_TRAIL;
      r2 = ROLE_TRAIL;
      case (sec)
        3'd1: begin r0 = ROLE_MID;   r1 = ROLE_LEAD;  r2 = ROLE_TRAIL; end
        3'd2: begin r0 = ROLE_TRAIL; r1 = ROLE_MID;   r2 = ROLE_LEAD;  end
        3'd3: begin r0 = ROLE_TRAIL; r1 = ROLE_LEAD;  r2 = ROLE_MID;   end
        3'd4: begin r0 = ROLE_LEAD;  r1 = ROLE_TRAIL; r2 = ROLE_MID;   end
        3'd5: begin r0 = ROLE_LEAD;  r1 = ROLE_MID;   r2 = ROLE_TRAIL; end
        3'd6: begin r0 = ROLE_MID;   r1 = ROLE_TRAIL; r2 = ROLE_LEAD;  end
        default: begin r0 = ROLE_TRAIL; r1 = ROLE_TRAIL; r2 = ROLE_TRAIL; end
      endcase
      case (ph)
        2'd0:    phase_role = r0;
        2'd1:    phase_role = r1;
        default: phase_role = r2;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/svpd_proj.sv
// Two pipeline stages: axis projections, sector code and active-time selection.
`default_nettype none
module svpd_proj #(
  parameter int FRAC_BITS = 15,
  localparam int TW = FRAC_BITS + 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire svpd_pkg::in_t    vin,
  output logic                  out_valid,
  output logic [2:0]            sector,
  output logic [TW-1:0]         tx,
  output logic [TW-1:0]         ty
);

  localparam int UW = FRAC_BITS + 18;
  localparam logic [63:0] KQ =
    (64'd3719550787 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic signed [UW-1:0] K_S = UW'(KQ);

  logic                 valid1;
  logic signed [UW-1:0] prod, u1, hb;
  logic signed [UW-1:0] u2, u3, sx, sy;
  logic [2:0]           sec;

  // Stage one: scale alpha by sqrt3/2, shift beta
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    prod <= UW'(vin.v_alpha) * K_S;
    u1   <= UW'(vin.v_beta) <<< FRAC_BITS;
    hb   <= UW'(vin.v_beta) <<< (FRAC_BITS - 1);
  end

  // Stage two: remaining projections, sector code, active-time pick
  always_comb begin
    u2 = -prod - hb;
    u3 = prod - hb;
    sec = {(!u3[UW-1] && (|u3)), (!u2[UW-1] && (|u2)), (!u1[UW-1] && (|u1))};
    case (sec)
      3'd5:    begin sx = u3;  sy = u1;  end
      3'd1:    begin sx = -u3; sy = -u2; end
      3'd3:    begin sx = u1;  sy = u2;  end
      3'd2:    begin sx = -u1; sy = -u3; end
      3'd6:    begin sx = u2;  sy = u3;  end
      3'd4:    begin sx = -u2; sy = -u1; end
      default: begin sx = '0;  sy = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
    sector <= sec;
    tx     <= sx[UW-1] ? '0 : sx[TW-1:0];
    ty     <= sy[UW-1] ? '0 : sy[TW-1:0];
  end

endmodule
`default_nettype wire

FILE: sv/svpd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none
module svpd_div #(
  parameter int DW = 33,
  localparam int CW = DW + 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [CW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  input  wire svpd_pkg::mid_t side_in,
  output logic                out_valid,
  output logic [15:0]         quo,
  output svpd_pkg::mid_t      side_out
);

  logic           vld  [0:16];
  logic [CW-1:0]  rem  [0:16];
  logic [DW-1:0]  dv   [0:16];
  logic [15:0]    qb   [0:16];
  svpd_pkg::mid_t sd   [0:16];

  assign vld[0] = in_valid;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign qb[0]  = '0;
  assign sd[0]  = side_in;

  // Resolve one quotient bit per stage, most significant first
  for (genvar j = 0; j < 16; j++) begin : g_stage
    logic [CW-1:0] shifted;
    logic          take;
    always_comb begin
      shifted = CW'(dv[j]) << (15 - j);
      take    = rem[j] >= shifted;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      rem[j+1] <= take ? rem[j] - shifted : rem[j];
      dv[j+1]  <= dv[j];
      qb[j+1]  <= qb[j] | (take ? (16'd1 << (15 - j)) : 16'd0);
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = vld[16];
  assign quo       = qb[16];
  assign side_out  = sd[16];

endmodule
`default_nettype wire

FILE: sv/svpd_mix.sv
// Output stage: choose active times, split zero-vector time, assign phase duties.
`default_nettype none
module svpd_mix (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [15:0]    quo,
  input  wire svpd_pkg::mid_t side,
  output logic                done,
  output svpd_pkg::out_t      duty
);

  logic [16:0] x, s, y, t7;
  logic [16:0] d [0:2];
  svpd_pkg::role_t r;

  // Pick limited or rounded times, then build each phase duty
  always_comb begin
    if (side.limited) begin
      x = ({1'b0, quo} > svpd_pkg::DUTY_ONE) ? svpd_pkg::DUTY_ONE : {1'b0, quo};
      s = svpd_pkg::DUTY_ONE;
    end else begin
      x = side.x;
      s = side.s;
    end
    y  = s - x;
    t7 = (svpd_pkg::DUTY_ONE - s) >> 1;
    r  = svpd_pkg::ROLE_TRAIL;
    for (int p = 0; p < 3; p++) begin
      r = svpd_pkg::phase_role(side.sector, 2'(p));
      case (r)
        svpd_pkg::ROLE_LEAD: d[p] = t7 + s;
        svpd_pkg::ROLE_MID:  d[p] = t7 + y;
        default:             d[p] = t7;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    duty.duty_a      <= d[0][15:0];
    duty.duty_b      <= d[1][15:0];
    duty.duty_c      <= d[2][15:0];
    duty.sector_code <= side.sector;
    duty.limited     <= side.limited;
  end

endmodule
`default_nettype wire

FILE: sv/space_vector_pwm_duty.sv
// An accepted transaction passes the projection, sum, divider and output registers to its done strobe.
// Throughput: one transaction per cycle; busy stays low, every stage is pipelined
// and the overmodulation divider resolves one quotient bit in each of its 16 stages.
// Each result shows for one cycle with done; the receiver cannot stall.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module space_vector_pwm_duty #(
  parameter int FRAC_BITS = 15
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire svpd_pkg::in_t  volts,
  output logic                done,
  output svpd_pkg::out_t      duty
);

  localparam int TW  = FRAC_BITS + 17;
  localparam int SW  = FRAC_BITS + 18;
  localparam int CW  = SW + 16;
  localparam int LAT = 20;

  logic           p_valid;
  logic [2:0]     p_sec;
  logic [TW-1:0]  p_tx, p_ty;
  logic [SW-1:0]  sum, sum_r, tx_r;
  logic [16:0]    s_rnd, x_rnd;
  logic           lim;

  logic           v3;
  svpd_pkg::mid_t mid3, d_side;
  logic [CW-1:0]  num3;
  logic [SW-1:0]  den3;
  logic           d_valid;
  logic [15:0]    d_quo;

  assign busy = 1'b0;

  svpd_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .vin       (volts),
    .out_valid (p_valid),
    .sector    (p_sec),
    .tx        (p_tx),
    .ty        (p_ty)
  );

  // Sum the active times, detect overmodulation, round to Q1.15
  always_comb begin
    tx_r  = SW'(p_tx);
    sum   = tx_r + SW'(p_ty);
    lim   = sum > (SW'(1) << (15 + FRAC_BITS));
    sum_r = sum + (SW'(1) << (FRAC_BITS - 1));
    s_rnd = sum_r[FRAC_BITS+16:FRAC_BITS];
    x_rnd = 17'((tx_r + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    if (x_rnd > s_rnd) begin
      x_rnd = s_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= p_valid;
    end
    mid3.sector  <= p_sec;
    mid3.limited <= lim;
    mid3.s       <= s_rnd;
    mid3.x       <= x_rnd;
    num3         <= (CW'(p_tx) << 15) + CW'(sum >> 1);
    den3         <= sum;
  end

  svpd_div #(.DW(SW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num3),
    .den       (den3),
    .side_in   (mid3),
    .out_valid (d_valid),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  svpd_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .quo      (d_quo),
    .side     (d_side),
    .done     (done),
    .duty     (duty)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  a_zero_ref: assert property (@(posedge clk) disable iff (rst)
    done && (duty.sector_code == 3'd0 || duty.sector_code == 3'd7) |->
      duty.duty_a == 16'd16384 && duty.duty_b == 16'd16384 && duty.duty_c == 16'd16384
      && !duty.limited)
    else $error("zero reference gives wrong duties");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> duty.duty_a <= 16'd32768 && duty.duty_b <= 16'd32768
      && duty.duty_c <= 16'd32768)
    else $error("duty beyond full period");
`endif

endmodule
`default_nettype wire

FILE: verif/space_vector_pwm_duty_checker.sv
// Checker for the space-vector PWM duty block: predicts duties and compares transactions.
`default_nettype none
module space_vector_pwm_duty_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic           busy,
  input  wire svpd_pkg::in_t  volts,
  input  wire logic           done,
  input  wire svpd_pkg::out_t duty,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 15;
  localparam longint HALF_SQRT3_Q32 = 64'd3719550787;
  localparam longint ONE = 32768;

  svpd_pkg::out_t duty_queue[$];

  // Work out the phase duties for one reference vector
  function automatic svpd_pkg::out_t predict_duty(input svpd_pkg::in_t v);
    longint a, b, k, half_b, u1, u2, u3, tx, ty, sum, period, s, x15, y15, t7, d;
    logic [2:0] sec;
    logic lim;
    svpd_pkg::role_t r;
    svpd_pkg::out_t o;
    a = longint'(v.v_alpha);
    b = longint'(v.v_beta);
    k = (HALF_SQRT3_Q32 + (64'd1 << (31 - FRAC))) >>> (32 - FRAC);
    half_b = b * ((64'd1 << FRAC) / 2);
    u1 = b * (64'd1 << FRAC);
    u2 = -(k * a) - half_b;
    u3 = k * a - half_b;
    sec = {u3 > 0, u2 > 0, u1 > 0};
    case (sec)
      3'd5: begin tx = u3;  ty = u1;  end
      3'd1: begin tx = -u3; ty = -u2; end
      3'd3: begin tx = u1;  ty = u2;  end
      3'd2: begin tx = -u1; ty = -u3; end
      3'd6: begin tx = u2;  ty = u3;  end
      3'd4: begin tx = -u2; ty = -u1; end
      default: begin tx = 0; ty = 0; end
    endcase
    if (tx < 0) tx = 0;
    if (ty < 0) ty = 0;
    sum = tx + ty;
    period = 64'd1 << (15 + FRAC);
    lim = 1'b0;
    if (sum > period) begin
      lim = 1'b1;
      x15 = (tx * ONE + sum / 2) / sum;
      if (x15 > ONE) x15 = ONE;
      y15 = ONE - x15;
      s = ONE;
    end else begin
      s = (sum + (64'd1 << (FRAC - 1))) >>> FRAC;
      x15 = (tx + (64'd1 << (FRAC - 1))) >>> FRAC;
      if (x15 > s) x15 = s;
      y15 = s - x15;
    end
    t7 = (ONE - s) >>> 1;
    for (int p = 0; p < 3; p++) begin
      r = svpd_pkg::ROLE_TRAIL;
      case (sec)
        3'd1: r = (p == 0) ? svpd_pkg::ROLE_MID :
                  (p == 1) ? svpd_pkg::ROLE_LEAD : svpd_pkg::ROLE_TRAIL;
        3'd2: r = (p == 0) ? svpd_pkg::ROLE_TRAIL :
                  (p == 1) ? svpd_pkg::ROLE_MID : svpd_pkg::ROLE_LEAD;
        3'd3: r = (p == 0) ? svpd_pkg::ROLE_TRAIL :
                  (p == 1) ? svpd_pkg::ROLE_LEAD : svpd_pkg::ROLE_MID;
        3'd4: r = (p == 0) ? svpd_pkg::ROLE_LEAD :
                  (p == 1) ? svpd_pkg::ROLE_TRAIL : svpd_pkg::ROLE_MID;
        3'd5: r = (p == 0) ? svpd_pkg::ROLE_LEAD :
                  (p == 1) ? svpd_pkg::ROLE_MID : svpd_pkg::ROLE_TRAIL;
        3'd6: r = (p == 0) ? svpd_pkg::ROLE_MID :
                  (p == 1) ? svpd_pkg::ROLE_TRAIL : svpd_pkg::ROLE_LEAD;
        default: r = svpd_pkg::ROLE_TRAIL;
      endcase
      d = t7;
      if (r == svpd_pkg::ROLE_LEAD) d = d + s;
      else if (r == svpd_pkg::ROLE_MID) d = d + y15;
      if (p == 0) o.duty_a = d[15:0];
      else if (p == 1) o.duty_b = d[15:0];
      else o.duty_c = d[15:0];
    end
    o.sector_code = sec;
    o.limited = lim;
    return o;
  endfunction

  assign pending = duty_queue.size();

  // Queue predictions on accepted transactions, compare on each done strobe
  always @(posedge clk) begin
    svpd_pkg::out_t want;
    if (rst) begin
      duty_queue.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) duty_queue.push_back(predict_duty(volts));
      if (done) begin
        if (duty_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %h", duty);
          fail_count <= fail_count + 1;
        end else begin
          want = duty_queue.pop_front();
          if (duty !== want) begin
            if (fail_count < 10)
              $display({"mismatch: exp a=%0d b=%0d c=%0d sec=%0d lim=%0b",
                        " got a=%0d b=%0d c=%0d sec=%0d lim=%0b"},
                       want.duty_a, want.duty_b, want.duty_c, want.sector_code,
                       want.limited, duty.duty_a, duty.duty_b, duty.duty_c,
                       duty.sector_code, duty.limited);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: verif/space_vector_pwm_duty_test.sv
// Testbench top for the space-vector PWM duty block: stimulus and verdict.
`default_nettype none
module space_vector_pwm_duty_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  svpd_pkg::in_t volts = '0;
  svpd_pkg::out_t duty;
  int fail_count, pending;

  space_vector_pwm_duty dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .volts(volts), .done(done), .duty(duty)
  );

  space_vector_pwm_duty_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .volts(volts),
    .done(done), .duty(duty), .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold one transaction until accepted
  task automatic send_volts(input logic [15:0] al, input logic [15:0] be);
    volts.v_alpha <= al;
    volts.v_beta <= be;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Pick a reference: half in a moderate range, the rest extremes and noise
  task automatic send_random(input bit with_gaps);
    logic [15:0] al, be;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      al = 16'($signed($urandom_range(0, 37836)) - 18918);
      be = 16'($signed($urandom_range(0, 37836)) - 18918);
    end else if (mode < 8) begin
      al = 16'($urandom);
      be = 16'($urandom);
    end else begin
      al = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
      be = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom);
    end
    if (with_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    send_volts(al, be);
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [15:0] corners [10];
    int n;
    corners = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
                16'h4000, 16'hc000, 16'h49e7, 16'h6ed9, 16'h93cd};
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed: zero reference, axis and corner extremes
    send_volts(16'h0000, 16'h0000);
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) send_volts(corners[i * 2], corners[j * 2 + 1]);
    end
    // Random with bursts of idling, then back-to-back
    for (n = 0; n < 1500; n++) send_random(1'b1);
    for (n = 0; n < 250; n++) send_random(1'b0);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
